// ----- rtl/hdrc_pkg.sv -----
package hdrc_pkg;

    localparam int SLOTS = 32;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam int GROUP_W = 32;
    localparam int YEAR_W = 14;
    localparam int DATE_W = 27;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam int HASH_SHIFT = 16;
    localparam int HASH_W = HASH_SHIFT + SLOT_W;
    localparam logic [GROUP_W-1:0] HASH_GROUP_MUL = 32'd2654435761;
    localparam logic [GROUP_W-1:0] HASH_YEAR_MUL = 32'd2246822519;

    localparam int BASE_W = 28;
    localparam logic [BASE_W-1:0] YEAR_SCALE = 28'd10000;
    localparam int MUL100_W = 13;
    localparam logic [MUL100_W-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;
    localparam int CENT_W = 8;
    localparam int MD_W = 14;
    localparam logic [MD_W-1:0] MONTH_SCALE = 14'd100;

    localparam logic [YEAR_W-1:0] YEAR_MIN_RESET = 14'd1982;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RESET = 14'd2100;

    localparam int REG_SEL_BIT = 2;
    localparam logic REG_YEAR_MIN = 1'b0;
    localparam logic REG_YEAR_MAX = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_FLUSH  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [GROUP_W-1:0]  group_id;
        logic [YEAR_W-1:0]   key_year;
        logic [DATE_W-1:0]   date_value;
        logic [DATE_W-1:0]   seen_date;
    } item_t;

    typedef struct packed {
        item_t               item;
        logic [SLOT_W-1:0]   slot;
        logic                year_ok;
        logic                date_ok;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic                stored;
        logic [DATE_W-1:0]   out_date;
        logic [DATE_W-1:0]   out_seen;
    } result_t;

endpackage

// ----- rtl/hdrc_hash.sv -----
module hdrc_hash (
    input  logic                          clk,
    input  logic [hdrc_pkg::GROUP_W-1:0]  group_id,
    input  logic [hdrc_pkg::YEAR_W-1:0]   key_year,
    output logic [hdrc_pkg::SLOT_W-1:0]   slot
);

    // Only the low bits of each product reach the slot index after the fold.
    logic [hdrc_pkg::HASH_W-1:0] group_prod_next;
    logic [hdrc_pkg::HASH_W-1:0] group_prod_reg;
    logic [hdrc_pkg::HASH_W-1:0] year_prod_next;
    logic [hdrc_pkg::HASH_W-1:0] year_prod_reg;
    logic [hdrc_pkg::HASH_W-1:0] year_ext;
    logic [hdrc_pkg::HASH_W-1:0] mix;

    always_comb
    begin
        year_ext = {{(hdrc_pkg::HASH_W - hdrc_pkg::YEAR_W){1'b0}}, key_year};
        group_prod_next = group_id[hdrc_pkg::HASH_W-1:0]
                        * hdrc_pkg::HASH_GROUP_MUL[hdrc_pkg::HASH_W-1:0];
        year_prod_next = year_ext * hdrc_pkg::HASH_YEAR_MUL[hdrc_pkg::HASH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        group_prod_reg <= group_prod_next;
        year_prod_reg <= year_prod_next;
    end

    always_comb
    begin
        mix = group_prod_reg ^ year_prod_reg;
        slot = mix[hdrc_pkg::SLOT_W-1:0]
             ^ mix[hdrc_pkg::HASH_W-1:hdrc_pkg::HASH_SHIFT];
    end

endmodule

// ----- rtl/hdrc_date_check.sv -----
module hdrc_date_check (
    input  logic                          clk,
    input  logic [hdrc_pkg::YEAR_W-1:0]   key_year,
    input  logic [hdrc_pkg::DATE_W-1:0]   date_value,
    input  logic [hdrc_pkg::YEAR_W-1:0]   year_min,
    input  logic [hdrc_pkg::YEAR_W-1:0]   year_max,
    output logic                          year_ok,
    output logic                          date_ok
);

    localparam int CentProdW = hdrc_pkg::YEAR_W + hdrc_pkg::MUL100_W;

    logic                                year_ok_next;
    logic                                year_ok_reg;
    logic [hdrc_pkg::BASE_W-1:0]         year_base_next;
    logic [hdrc_pkg::BASE_W-1:0]         year_base_reg;
    logic [CentProdW-1:0]                cent_prod;
    logic [hdrc_pkg::CENT_W-1:0]         cent_next;
    logic [hdrc_pkg::CENT_W-1:0]         cent_reg;
    logic [hdrc_pkg::YEAR_W-1:0]         year_reg;
    logic [hdrc_pkg::DATE_W-1:0]         date_reg;

    logic [hdrc_pkg::BASE_W-1:0]         date_ext;
    logic [hdrc_pkg::BASE_W-1:0]         rest;
    logic                                in_year;
    logic [hdrc_pkg::MD_W-1:0]           month_day;
    logic [hdrc_pkg::MD_W-1:0]           cent_hund;
    logic                                century;
    logic                                leap;
    logic                                day_ok;

    function automatic logic [4:0] month_days(input int month, input logic leap_year);
        logic [4:0] days;
        begin
            case (month)
                2:
                begin
                    days = leap_year ? 5'd29 : 5'd28;
                end
                4, 6, 9, 11:
                begin
                    days = 5'd30;
                end
                default:
                begin
                    days = 5'd31;
                end
            endcase
            return days;
        end
    endfunction

    // First stage: bounds check, year scaled to the date's decimal position,
    // and the year divided by one hundred through a reciprocal.
    always_comb
    begin
        year_ok_next = (key_year != '0) && (key_year >= year_min) && (key_year <= year_max);
        year_base_next = {{(hdrc_pkg::BASE_W - hdrc_pkg::YEAR_W){1'b0}}, key_year}
                       * hdrc_pkg::YEAR_SCALE;
        cent_prod = {{hdrc_pkg::MUL100_W{1'b0}}, key_year}
                  * {{hdrc_pkg::YEAR_W{1'b0}}, hdrc_pkg::DIV100_MUL};
        cent_next = cent_prod[hdrc_pkg::DIV100_SHIFT +: hdrc_pkg::CENT_W];
    end

    always_ff @(posedge clk)
    begin
        year_ok_reg <= year_ok_next;
        year_base_reg <= year_base_next;
        cent_reg <= cent_next;
        year_reg <= key_year;
        date_reg <= date_value;
    end

    // Second stage: the date must sit inside the key year, and its month and
    // day part must name a real Gregorian day.
    always_comb
    begin
        logic [hdrc_pkg::MD_W-1:0] lo;
        logic [hdrc_pkg::MD_W-1:0] hi;
        date_ext = {{(hdrc_pkg::BASE_W - hdrc_pkg::DATE_W){1'b0}}, date_reg};
        in_year = date_ext >= year_base_reg;
        rest = date_ext - year_base_reg;
        month_day = rest[hdrc_pkg::MD_W-1:0];
        cent_hund = {{(hdrc_pkg::MD_W - hdrc_pkg::CENT_W){1'b0}}, cent_reg}
                  * hdrc_pkg::MONTH_SCALE;
        century = (year_reg == cent_hund);
        leap = (year_reg[1:0] == 2'b00) && (!century || (cent_reg[1:0] == 2'b00));
        day_ok = 1'b0;
        for (int m = 1; m <= 12; m++)
        begin
            lo = hdrc_pkg::MD_W'(m * 100 + 1);
            hi = hdrc_pkg::MD_W'(m * 100) + {{(hdrc_pkg::MD_W - 5){1'b0}}, month_days(m, leap)};
            if ((month_day >= lo) && (month_day <= hi))
            begin
                day_ok = 1'b1;
            end
        end
        year_ok = year_ok_reg;
        date_ok = year_ok_reg && in_year && (rest < hdrc_pkg::YEAR_SCALE) && day_ok;
    end

endmodule

// ----- rtl/hdrc_slot_store.sv -----
module hdrc_slot_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  hdrc_pkg::req_t    req,
    output logic              done,
    output hdrc_pkg::result_t result
);

    logic [hdrc_pkg::SLOTS-1:0]    valid_reg;
    logic [hdrc_pkg::SLOTS-1:0]    valid_next;
    logic [hdrc_pkg::GROUP_W-1:0]  group_reg [hdrc_pkg::SLOTS];
    logic [hdrc_pkg::YEAR_W-1:0]   year_reg [hdrc_pkg::SLOTS];
    logic [hdrc_pkg::DATE_W-1:0]   date_reg [hdrc_pkg::SLOTS];
    logic [hdrc_pkg::DATE_W-1:0]   seen_reg [hdrc_pkg::SLOTS];
    logic                          done_reg;
    hdrc_pkg::result_t             result_reg;
    hdrc_pkg::result_t             result_next;
    logic                          match;
    logic                          write_en;

    // A stored entry already passed the calendar check, so on a lookup only
    // the current year bounds are left to test.
    always_comb
    begin
        match = valid_reg[req.slot]
             && (group_reg[req.slot] == req.item.group_id)
             && (year_reg[req.slot] == req.item.key_year)
             && req.year_ok;
        result_next = '0;
        valid_next = valid_reg;
        write_en = 1'b0;
        case (req.item.kind)
            hdrc_pkg::KIND_LOOKUP:
            begin
                if (match)
                begin
                    result_next.hit = 1'b1;
                    result_next.out_date = date_reg[req.slot];
                    result_next.out_seen = seen_reg[req.slot];
                end
            end
            hdrc_pkg::KIND_STORE:
            begin
                if (req.date_ok)
                begin
                    result_next.stored = 1'b1;
                    write_en = req_valid;
                    if (req_valid)
                    begin
                        valid_next[req.slot] = 1'b1;
                    end
                end
            end
            hdrc_pkg::KIND_FLUSH:
            begin
                if (req_valid)
                begin
                    valid_next = '0;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (write_en)
        begin
            group_reg[req.slot] <= req.item.group_id;
            year_reg[req.slot] <= req.item.key_year;
            date_reg[req.slot] <= req.item.date_value;
            seen_reg[req.slot] <= req.item.seen_date;
        end
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/hdrc_cfg_regs.sv -----
module hdrc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hdrc_pkg::ADDR_W-1:0]  paddr,
    input  logic [hdrc_pkg::DATA_W-1:0]  pwdata,
    output logic [hdrc_pkg::DATA_W-1:0]  prdata,
    output logic [hdrc_pkg::YEAR_W-1:0]  year_min,
    output logic [hdrc_pkg::YEAR_W-1:0]  year_max
);

    logic [hdrc_pkg::YEAR_W-1:0] year_min_reg;
    logic [hdrc_pkg::YEAR_W-1:0] year_min_next;
    logic [hdrc_pkg::YEAR_W-1:0] year_max_reg;
    logic [hdrc_pkg::YEAR_W-1:0] year_max_next;
    logic                        write_en;
    logic [hdrc_pkg::YEAR_W-1:0] read_value;

    always_comb
    begin
        write_en = psel && penable && pwrite;
        year_min_next = year_min_reg;
        year_max_next = year_max_reg;
        read_value = '0;
        case (paddr[hdrc_pkg::REG_SEL_BIT])
            hdrc_pkg::REG_YEAR_MIN:
            begin
                read_value = year_min_reg;
                if (write_en)
                begin
                    year_min_next = pwdata[hdrc_pkg::YEAR_W-1:0];
                end
            end
            hdrc_pkg::REG_YEAR_MAX:
            begin
                read_value = year_max_reg;
                if (write_en)
                begin
                    year_max_next = pwdata[hdrc_pkg::YEAR_W-1:0];
                end
            end
            default:
            begin
                read_value = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_min_reg <= hdrc_pkg::YEAR_MIN_RESET;
            year_max_reg <= hdrc_pkg::YEAR_MAX_RESET;
        end
        else
        begin
            year_min_reg <= year_min_next;
            year_max_reg <= year_max_next;
        end
    end

    assign prdata = {{(hdrc_pkg::DATA_W - hdrc_pkg::YEAR_W){1'b0}}, read_value};
    assign year_min = year_min_reg;
    assign year_max = year_max_reg;

endmodule

// ----- rtl/hashed_date_record_cache_core.sv -----
// Path: done and the result ports show a word once it has passed the input register,
// the hash and date stage, the slot stage and the result register.
// Throughput: one word per cycle; busy stays low, as every stage moves on each clock.
// Reset clears all valid marks, empties the pipeline and loads the year bounds 1982 and 2100.
// Each result word is shown for exactly one cycle; the receiver cannot stall it.
module hashed_date_record_cache_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [hdrc_pkg::GROUP_W-1:0]  group_id,
    input  logic [hdrc_pkg::YEAR_W-1:0]   key_year,
    input  logic [hdrc_pkg::DATE_W-1:0]   date_value,
    input  logic [hdrc_pkg::DATE_W-1:0]   seen_date,
    output logic                          done,
    output logic                          hit,
    output logic                          stored,
    output logic [hdrc_pkg::DATE_W-1:0]   out_date,
    output logic [hdrc_pkg::DATE_W-1:0]   out_seen,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hdrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [hdrc_pkg::DATA_W-1:0]   pwdata,
    output logic [hdrc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s2_valid_reg;
    logic                          s3_valid_reg;
    hdrc_pkg::item_t               s1_item_reg;
    hdrc_pkg::item_t               s1_item_next;
    hdrc_pkg::item_t               s2_item_reg;
    hdrc_pkg::req_t                s3_req_reg;
    hdrc_pkg::req_t                s3_req_next;
    logic [hdrc_pkg::SLOT_W-1:0]   slot;
    logic                          year_ok;
    logic                          date_ok;
    logic [hdrc_pkg::YEAR_W-1:0]   year_min;
    logic [hdrc_pkg::YEAR_W-1:0]   year_max;
    hdrc_pkg::result_t             result;

    always_comb
    begin
        s1_valid_next = start && !busy;
        s1_item_next.kind = hdrc_pkg::kind_t'(kind);
        s1_item_next.group_id = group_id;
        s1_item_next.key_year = key_year;
        s1_item_next.date_value = date_value;
        s1_item_next.seen_date = seen_date;
        s3_req_next.item = s2_item_reg;
        s3_req_next.slot = slot;
        s3_req_next.year_ok = year_ok;
        s3_req_next.date_ok = date_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        s2_item_reg <= s1_item_reg;
        s3_req_reg <= s3_req_next;
    end

    hdrc_hash u_hash (
        .clk      (clk),
        .group_id (s1_item_reg.group_id),
        .key_year (s1_item_reg.key_year),
        .slot     (slot)
    );

    hdrc_date_check u_date_check (
        .clk        (clk),
        .key_year   (s1_item_reg.key_year),
        .date_value (s1_item_reg.date_value),
        .year_min   (year_min),
        .year_max   (year_max),
        .year_ok    (year_ok),
        .date_ok    (date_ok)
    );

    hdrc_slot_store u_slot_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s3_valid_reg),
        .req       (s3_req_reg),
        .done      (done),
        .result    (result)
    );

    hdrc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .year_min (year_min),
        .year_max (year_max)
    );

    assign busy = 1'b0;
    assign pready = 1'b1;
    assign hit = result.hit;
    assign stored = result.stored;
    assign out_date = result.out_date;
    assign out_seen = result.out_seen;

endmodule

// ----- test/hashed_date_record_cache_core_test.sv -----
`timescale 1ns / 100ps

module hashed_date_record_cache_core_test;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [hdrc_pkg::ADDR_W-1:0] ADDR_YEAR_MIN =
        hdrc_pkg::ADDR_W'(hdrc_pkg::REG_YEAR_MIN) << hdrc_pkg::REG_SEL_BIT;
    localparam logic [hdrc_pkg::ADDR_W-1:0] ADDR_YEAR_MAX =
        hdrc_pkg::ADDR_W'(hdrc_pkg::REG_YEAR_MAX) << hdrc_pkg::REG_SEL_BIT;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int BLOCKS = 8;
    localparam int BLOCK_WORDS = 200;
    localparam int POOL = 24;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [hdrc_pkg::GROUP_W-1:0] group_id;
        logic [hdrc_pkg::YEAR_W-1:0]  key_year;
        logic [hdrc_pkg::DATE_W-1:0]  date_value;
        logic [hdrc_pkg::DATE_W-1:0]  seen_date;
    } word_t;

    class date_cache_scoreboard;
        bit                           slot_valid [hdrc_pkg::SLOTS];
        logic [hdrc_pkg::GROUP_W-1:0] slot_group [hdrc_pkg::SLOTS];
        logic [hdrc_pkg::YEAR_W-1:0]  slot_year [hdrc_pkg::SLOTS];
        logic [hdrc_pkg::DATE_W-1:0]  slot_date [hdrc_pkg::SLOTS];
        logic [hdrc_pkg::DATE_W-1:0]  slot_seen [hdrc_pkg::SLOTS];
        logic [hdrc_pkg::YEAR_W-1:0]  year_lo;
        logic [hdrc_pkg::YEAR_W-1:0]  year_hi;
        hdrc_pkg::result_t            pending_q [$];
        int                           errors;

        function new();
            year_lo = hdrc_pkg::YEAR_MIN_RESET;
            year_hi = hdrc_pkg::YEAR_MAX_RESET;
            errors = 0;
            foreach (slot_valid[i])
                slot_valid[i] = 1'b0;
        endfunction

        function logic [hdrc_pkg::SLOT_W-1:0] slot_index(logic [hdrc_pkg::GROUP_W-1:0] g,
                                                         logic [hdrc_pkg::YEAR_W-1:0] y);
            logic [31:0] h;
            h = (g * hdrc_pkg::HASH_GROUP_MUL) ^ (32'(y) * hdrc_pkg::HASH_YEAR_MUL);
            h = h ^ (h >> hdrc_pkg::HASH_SHIFT);
            return h[hdrc_pkg::SLOT_W-1:0];
        endfunction

        function int unsigned month_length(int unsigned y, int unsigned m);
            bit leap;
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            if (m == 2)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        function bit date_valid(logic [hdrc_pkg::YEAR_W-1:0] y, logic [hdrc_pkg::DATE_W-1:0] d);
            int unsigned dy;
            int unsigned m;
            int unsigned dd;
            dy = d / 10000;
            m = (d / 100) % 100;
            dd = d % 100;
            if (y < year_lo || y > year_hi || dy != y)
                return 1'b0;
            if (m < 1 || m > 12 || dd < 1)
                return 1'b0;
            return dd <= month_length(dy, m);
        endfunction

        function void note_word(word_t w);
            hdrc_pkg::result_t r;
            logic [hdrc_pkg::SLOT_W-1:0] s;
            r = '0;
            s = slot_index(w.group_id, w.key_year);
            if (w.kind == hdrc_pkg::KIND_LOOKUP)
            begin
                if (w.key_year != 0 && slot_valid[s] && slot_group[s] == w.group_id
                    && slot_year[s] == w.key_year && date_valid(slot_year[s], slot_date[s]))
                begin
                    r.hit = 1'b1;
                    r.out_date = slot_date[s];
                    r.out_seen = slot_seen[s];
                end
            end
            else if (w.kind == hdrc_pkg::KIND_STORE)
            begin
                if (w.key_year != 0 && date_valid(w.key_year, w.date_value))
                begin
                    slot_valid[s] = 1'b1;
                    slot_group[s] = w.group_id;
                    slot_year[s] = w.key_year;
                    slot_date[s] = w.date_value;
                    slot_seen[s] = w.seen_date;
                    r.stored = 1'b1;
                end
            end
            else if (w.kind == hdrc_pkg::KIND_FLUSH)
            begin
                foreach (slot_valid[i])
                    slot_valid[i] = 1'b0;
            end
            pending_q.push_back(r);
        endfunction

        function void report(string field, logic [hdrc_pkg::DATE_W-1:0] want,
                             logic [hdrc_pkg::DATE_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_word(hdrc_pkg::result_t got);
            hdrc_pkg::result_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result word with none expected, actual hit %0d stored %0d",
                         $time, got.hit, got.stored);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            report("hit", hdrc_pkg::DATE_W'(want.hit), hdrc_pkg::DATE_W'(got.hit));
            report("stored", hdrc_pkg::DATE_W'(want.stored), hdrc_pkg::DATE_W'(got.stored));
            report("out_date", want.out_date, got.out_date);
            report("out_seen", want.out_seen, got.out_seen);
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    kind = '0;
    logic [hdrc_pkg::GROUP_W-1:0]  group_id = '0;
    logic [hdrc_pkg::YEAR_W-1:0]   key_year = '0;
    logic [hdrc_pkg::DATE_W-1:0]   date_value = '0;
    logic [hdrc_pkg::DATE_W-1:0]   seen_date = '0;
    logic                          done;
    logic                          hit;
    logic                          stored;
    logic [hdrc_pkg::DATE_W-1:0]   out_date;
    logic [hdrc_pkg::DATE_W-1:0]   out_seen;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [hdrc_pkg::ADDR_W-1:0]   paddr = '0;
    logic [hdrc_pkg::DATA_W-1:0]   pwdata = '0;
    logic [hdrc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    date_cache_scoreboard sb = new();
    int idle_pct = 0;
    int stall_cycles = 0;
    logic [hdrc_pkg::GROUP_W-1:0] pool_group [POOL];
    logic [hdrc_pkg::YEAR_W-1:0]  pool_year [POOL];

    hashed_date_record_cache_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .group_id   (group_id),
        .key_year   (key_year),
        .date_value (date_value),
        .seen_date  (seen_date),
        .done       (done),
        .hit        (hit),
        .stored     (stored),
        .out_date   (out_date),
        .out_seen   (out_seen),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(hdrc_pkg::result_t'({hit, stored, out_date, out_seen}));
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic word_t mk(logic [1:0] k, logic [hdrc_pkg::GROUP_W-1:0] g,
                                 logic [hdrc_pkg::YEAR_W-1:0] y,
                                 logic [hdrc_pkg::DATE_W-1:0] d,
                                 logic [hdrc_pkg::DATE_W-1:0] s);
        word_t w;
        w.kind = k;
        w.group_id = g;
        w.key_year = y;
        w.date_value = d;
        w.seen_date = s;
        return w;
    endfunction

    function automatic logic [hdrc_pkg::DATE_W-1:0] rand_date();
        return hdrc_pkg::DATE_W'($urandom_range(99999999));
    endfunction

    function automatic logic [hdrc_pkg::YEAR_W-1:0] rand_year();
        return hdrc_pkg::YEAR_W'($urandom_range(9999));
    endfunction

    function automatic logic [hdrc_pkg::DATE_W-1:0] real_date(logic [hdrc_pkg::YEAR_W-1:0] y);
        int unsigned m;
        int unsigned dd;
        m = $urandom_range(12, 1);
        dd = $urandom_range(sb.month_length(y, m), 1);
        return hdrc_pkg::DATE_W'(y * 10000 + m * 100 + dd);
    endfunction

    function automatic logic [hdrc_pkg::YEAR_W-1:0] bounded_year();
        if ($urandom_range(99) < 85)
            return hdrc_pkg::YEAR_W'($urandom_range(sb.year_hi, sb.year_lo));
        return rand_year();
    endfunction

    function automatic word_t make_word();
        int unsigned sel;
        int unsigned k;
        logic [hdrc_pkg::DATE_W-1:0] d;
        sel = $urandom_range(99);
        k = $urandom_range(POOL - 1);
        if (sel < 42)
        begin
            if ($urandom_range(9) == 0)
                d = hdrc_pkg::DATE_W'(pool_year[k] * 10000 + $urandom_range(9999));
            else
                d = real_date(pool_year[k]);
            return mk(hdrc_pkg::KIND_STORE, pool_group[k], pool_year[k], d, rand_date());
        end
        if (sel < 80)
            return mk(hdrc_pkg::KIND_LOOKUP, pool_group[k], pool_year[k], rand_date(),
                      rand_date());
        if (sel < 82)
            return mk(hdrc_pkg::KIND_FLUSH, $urandom, rand_year(), rand_date(), rand_date());
        if (sel < 85)
            return mk(KIND_SPARE, $urandom, rand_year(), rand_date(), rand_date());
        return mk(2'($urandom_range(1)), $urandom, rand_year(), rand_date(), rand_date());
    endfunction

    task automatic send_word(input word_t w);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        kind = w.kind;
        group_id = w.group_id;
        key_year = w.key_year;
        date_value = w.date_value;
        seen_date = w.seen_date;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(w);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hdrc_pkg::ADDR_W-1:0] addr,
                             input logic [hdrc_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_bounds(input logic [hdrc_pkg::YEAR_W-1:0] lo,
                              input logic [hdrc_pkg::YEAR_W-1:0] hi);
        wait_drained();
        write_reg(ADDR_YEAR_MIN, hdrc_pkg::DATA_W'(lo));
        write_reg(ADDR_YEAR_MAX, hdrc_pkg::DATA_W'(hi));
        sb.year_lo = lo;
        sb.year_hi = hi;
    endtask

    initial
    begin
        logic [hdrc_pkg::YEAR_W-1:0] lo_list [BLOCKS];
        logic [hdrc_pkg::YEAR_W-1:0] hi_list [BLOCKS];
        int unsigned idx;
        lo_list = '{14'd0, 14'd1990, 14'd2024, 14'd9999, 14'd2030, 14'd0, 14'd1982, 14'd0};
        hi_list = '{14'd9999, 14'd2030, 14'd2024, 14'd9999, 14'd1990, 14'd0, 14'd2100, 14'd9999};
        foreach (pool_group[i])
        begin
            pool_group[i] = $urandom;
            pool_year[i] = bounded_year();
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Opening checks run under the reset year bounds.
        idle_pct = 29;
        send_word(mk(hdrc_pkg::KIND_STORE, 32'h1234_5678, 14'd2024, 27'd20240229, 27'd20240301));
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'h1234_5678, 14'd2024, 27'd0, 27'd0));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'h0, 14'd1982, 27'd19820101, 27'd0));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'hFFFF_FFFF, 14'd2100, 27'd21001231, 27'd99999999));
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'h0, 14'd1982, 27'd0, 27'd0));
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 14'd2100, 27'd0, 27'd0));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'd7, 14'd0, 27'd0, 27'd5));
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'd7, 14'd0, 27'd0, 27'd0));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'd7, 14'd2100, 27'd21000229, 27'd1));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'd7, 14'd2000, 27'd20000229, 27'd2));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'd8, 14'd2023, 27'd20231301, 27'd3));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'd8, 14'd2023, 27'd20230431, 27'd4));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'd8, 14'd2023, 27'd20240101, 27'd5));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'd8, 14'd1981, 27'd19810101, 27'd6));
        send_word(mk(hdrc_pkg::KIND_STORE, 32'd8, 14'd9999, 27'd99999999, 27'd7));
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'd8, 14'd2023, 27'd0, 27'd0));
        send_word(mk(KIND_SPARE, 32'hFFFF_FFFF, 14'd9999, 27'd99999999, 27'd99999999));
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'h1234_5678, 14'd2024, 27'd0, 27'd0));

        // Narrowed bounds hide the 1982 entry; the flush that follows removes it and all others.
        set_bounds(14'd2000, 14'd2050);
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'h0, 14'd1982, 27'd0, 27'd0));
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'h1234_5678, 14'd2024, 27'd0, 27'd0));
        send_word(mk(hdrc_pkg::KIND_FLUSH, 32'h0, 14'd0, 27'd0, 27'd0));
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'h1234_5678, 14'd2024, 27'd0, 27'd0));
        set_bounds(hdrc_pkg::YEAR_MIN_RESET, hdrc_pkg::YEAR_MAX_RESET);
        send_word(mk(hdrc_pkg::KIND_LOOKUP, 32'h0, 14'd1982, 27'd0, 27'd0));

        for (int b = 0; b < BLOCKS; b++)
        begin
            set_bounds(lo_list[b], hi_list[b]);
            idle_pct = (b < 3) ? 29 : (b < 6) ? 73 : 0;
            repeat (16)
            begin
                idx = $urandom_range(POOL - 1);
                pool_group[idx] = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom;
                pool_year[idx] = bounded_year();
            end
            repeat (BLOCK_WORDS) send_word(make_word());
        end

        wait_drained();
        if (sb.pending_q.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, sb.pending_q.size());
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
